[sv/wac_pkg.sv]
// shared types and constants of the wide accumulator with decimal readout
package wac_pkg;

  localparam int VALUE_BYTES  = 8;
  localparam int GROUP_DIGITS = 16;
  // t / 10 as (t * RECIP10) >> 16, exact for t below 2560
  localparam logic [12:0] RECIP10 = 13'd6554;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_SUB   = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_DEC
  } alu_op_t;

  typedef struct packed {
    logic [7:0] sum;
    logic       cout;
    logic [3:0] rem;
    logic [7:0] quo;
  } alu_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_ACC_RD,
    S_ACC_WAIT,
    S_DIG_RD,
    S_DIG_WR,
    S_APPEND,
    S_FIN,
    S_OUT_RD,
    S_OUT_COL,
    S_SEND
  } state_t;

endpackage

[sv/wac_ram.sv]
// generic single write port, single read port ram with registered read
module wac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/wac_alu.sv]
// shared byte adder/subtractor and multiply-by-256-plus-carry divide-by-ten unit
module wac_alu
  import wac_pkg::*;
(
  input  alu_op_t    op,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  logic       cin,
  input  logic [3:0] dig,
  input  logic [7:0] cdec,
  output alu_res_t   res
);

  logic [8:0]  sum9;
  logic [11:0] t;
  logic [24:0] prod;
  logic [7:0]  q;
  logic [11:0] qx10;

  always_comb begin
    unique case (op)
      ALU_SUB: sum9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
      ALU_ADD: sum9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
      default: sum9 = '0;
    endcase
  end

  // digit * 256 + carry, then split into quotient and remainder by ten
  assign t    = {dig, cdec};
  assign prod = {13'd0, t} * {12'd0, RECIP10};
  assign q    = prod[23:16];
  assign qx10 = {4'd0, q} * 12'd10;

  always_comb begin
    res.sum  = sum9[7:0];
    res.cout = sum9[8];
    res.quo  = q;
    res.rem  = 4'(t - qx10);
  end

endmodule

[sv/wide_accumulator_decimal_readout.sv]
// top level: wide accumulator, sequencer and decimal readout
//
// Input channel (in_valid / in_stall) carries func and value. A transfer
// happens on a rising edge with in_valid high and in_stall low. Clear leaves
// the sequencer idle. Add and subtract walk the accumulator bytes from least
// significant upward, each byte read (S_ADD_RD) and written (S_ADD_WR)
// through the shared byte adder: the eight value bytes, then each further
// byte that a carry or borrow ripples into, at most ACC_BYTES bytes.
// A readout converts the total by a shift-and-add over bytes: for each byte
// every decimal digit found so far goes through the shared times-256
// divide-by-ten unit, each digit read from (S_DIG_RD) and written back to
// (S_DIG_WR) the digit ram. Then each group of sixteen BCD digits is
// gathered and offered on the output channel (out_valid / out_stall), most
// significant group first, last set on the final group. A stalled result
// holds its fields until taken. in_stall stays high until the item,
// including all its results, is done.
// Reset empties the accumulator (per-byte valid bits) and the add count; the
// digit ram needs no clearing.
module wide_accumulator_decimal_readout
  import wac_pkg::*;
#(
  parameter int ACC_BYTES      = 256,
  parameter int DIGIT_CAPACITY = 640
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [63:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digits_bcd,
  output logic [9:0]  digit_count,
  output logic [31:0] add_count,
  output logic        last
);

  localparam int AAW = $clog2(ACC_BYTES);
  localparam int AW  = $clog2(DIGIT_CAPACITY);
  localparam int NW  = $clog2(DIGIT_CAPACITY + 1);

  state_t state, state_next;

  logic [AAW-1:0] k, b;
  logic [7:0]     carry;
  logic [63:0]    vreg;
  logic           op_sub;
  logic [31:0]    adds;
  logic [ACC_BYTES-1:0] vbits;
  logic           acc_vld_q;
  logic [NW-1:0]  j, n, g;
  logic [3:0]     p;
  logic [63:0]    word;
  logic           idx_ok_q;

  logic           acc_we;
  logic [AAW-1:0] acc_waddr, acc_raddr;
  logic [7:0]     acc_rdata, acc_byte;
  logic           dig_we;
  logic [AW-1:0]  dig_waddr, dig_raddr;
  logic [3:0]     dig_wdata, dig_rdata;

  alu_op_t    alu_op;
  logic [3:0] alu_dig;
  alu_res_t   res;

  logic              accept;
  logic              add_done, app, n_zero;
  logic [NW+3:0]     idx_w;
  logic [NW-1:0]     n_eff;

  assign accept   = in_valid && !in_stall;
  assign acc_byte = acc_vld_q ? acc_rdata : 8'd0;
  assign idx_w    = {g, p};
  assign n_zero   = (n == '0);
  assign n_eff    = n_zero ? NW'(1) : n;
  assign app      = (carry != 8'd0) && (n < NW'(DIGIT_CAPACITY));
  assign add_done = (k == AAW'(ACC_BYTES - 1)) ||
                    ((k >= AAW'(VALUE_BYTES - 1)) && !res.cout);

  wac_ram #(.WIDTH(8), .DEPTH(ACC_BYTES)) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (res.sum),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  wac_ram #(.WIDTH(4), .DEPTH(DIGIT_CAPACITY)) u_dig_ram (
    .clk   (clk),
    .we    (dig_we),
    .waddr (dig_waddr),
    .wdata (dig_wdata),
    .raddr (dig_raddr),
    .rdata (dig_rdata)
  );

  wac_alu u_alu (
    .op   (alu_op),
    .a    (acc_byte),
    .b    (vreg[7:0]),
    .cin  (carry[0]),
    .dig  (alu_dig),
    .cdec (carry),
    .res  (res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func_t'(func)) inside
            FUNC_ADD, FUNC_SUB: state_next = S_ADD_RD;
            FUNC_READ:          state_next = S_ACC_RD;
            default:            state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_RD:   state_next = S_ADD_WR;
      S_ADD_WR:   state_next = add_done ? S_IDLE : S_ADD_RD;
      S_ACC_RD:   state_next = S_ACC_WAIT;
      S_ACC_WAIT: state_next = n_zero ? S_APPEND : S_DIG_RD;
      S_DIG_RD:   state_next = S_DIG_WR;
      S_DIG_WR:   state_next = ((j + NW'(1)) == n) ? S_APPEND : S_DIG_RD;
      S_APPEND: begin
        if (!app) begin
          state_next = (b == AAW'(ACC_BYTES - 1)) ? S_FIN : S_ACC_RD;
        end
      end
      S_FIN:      state_next = S_OUT_RD;
      S_OUT_RD:   state_next = S_OUT_COL;
      S_OUT_COL:  state_next = (p == 4'd0) ? S_SEND : S_OUT_RD;
      S_SEND: begin
        if (!out_stall) begin
          state_next = (g == '0) ? S_IDLE : S_OUT_RD;
        end
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // memory ports, shared unit and handshake outputs
  always_comb begin
    in_stall  = (state != S_IDLE);
    out_valid = (state == S_SEND);
    acc_we    = 1'b0;
    acc_waddr = AAW'(ACC_BYTES - 1) - k;
    acc_raddr = AAW'(ACC_BYTES - 1) - k;
    dig_we    = 1'b0;
    dig_waddr = j[AW-1:0];
    dig_wdata = res.rem;
    dig_raddr = j[AW-1:0];
    alu_op    = op_sub ? ALU_SUB : ALU_ADD;
    alu_dig   = dig_rdata;
    unique case (state)
      S_ADD_WR: acc_we = 1'b1;
      S_ACC_RD: acc_raddr = b;
      S_DIG_WR: begin
        alu_op = ALU_DEC;
        dig_we = 1'b1;
      end
      S_APPEND: begin
        alu_op    = ALU_DEC;
        alu_dig   = 4'd0;
        dig_we    = app;
        dig_waddr = n[AW-1:0];
      end
      S_FIN: begin
        // zero total reads as a single digit 0
        dig_we    = n_zero;
        dig_waddr = '0;
        dig_wdata = 4'd0;
      end
      S_OUT_RD: dig_raddr = idx_w[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      adds  <= '0;
      vbits <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (func_t'(func))
          FUNC_CLEAR: begin
            vbits <= '0;
            adds  <= '0;
          end
          FUNC_ADD: begin
            if (adds != 32'hFFFF_FFFF) begin
              adds <= adds + 32'd1;
            end
          end
          default: ;
        endcase
      end
      if (acc_we) begin
        vbits[acc_waddr] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_vld_q <= vbits[acc_raddr];
    unique case (state)
      S_IDLE: begin
        k      <= '0;
        b      <= '0;
        n      <= '0;
        carry  <= '0;
        vreg   <= value;
        op_sub <= (func_t'(func) == FUNC_SUB);
      end
      S_ADD_WR: begin
        carry <= {7'd0, res.cout};
        vreg  <= vreg >> 8;
        k     <= k + AAW'(1);
      end
      S_ACC_WAIT: begin
        carry <= acc_byte;
        j     <= '0;
      end
      S_DIG_WR: begin
        carry <= res.quo;
        j     <= j + NW'(1);
      end
      S_APPEND: begin
        if (app) begin
          carry <= res.quo;
          n     <= n + NW'(1);
        end else begin
          b <= b + AAW'(1);
        end
      end
      S_FIN: begin
        n <= n_eff;
        g <= (n_eff - NW'(1)) >> 4;
        p <= 4'd15;
      end
      S_OUT_RD: idx_ok_q <= (idx_w < {4'd0, n});
      S_OUT_COL: begin
        word <= {word[59:0], idx_ok_q ? dig_rdata : 4'd0};
        p    <= p - 4'd1;
      end
      S_SEND: begin
        if (!out_stall) begin
          g <= g - NW'(1);
          p <= 4'd15;
        end
      end
      default: ;
    endcase
  end

  assign digits_bcd  = word;
  assign digit_count = 10'(n);
  assign add_count   = adds;
  assign last        = (g == '0);

endmodule

[sv/wac_checker.sv]
// port-level checker for the wide accumulator, bound to the top level
module wac_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] digits_bcd,
  input logic [9:0]  digit_count,
  input logic        last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digits_bcd) && $stable(last))
    else $error("stalled result changed");

  // results only while the input side is busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("result offered while input side is open");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> digit_count != 10'd0)
    else $error("readout with zero digit count");

  // the final group transfer frees the input side
  a_release: assert property (@(posedge clk) disable iff (rst)
    out_valid && last && !out_stall |=> !in_stall)
    else $error("input side not released after final group");

endmodule

bind wide_accumulator_decimal_readout wac_checker u_wac_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .digits_bcd  (digits_bcd),
  .digit_count (digit_count),
  .last        (last)
);
